// ===== sv/rsmp_pkg.sv =====
// Shared types, register indexes and constants for the reservoir sampler.
package rsmp_pkg;

    localparam logic ACT_OBSERVE = 1'b0;
    localparam logic ACT_DRAW    = 1'b1;

    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK = 8'd1;

    localparam logic [16:0] CAP_MAX        = 17'd65536;
    localparam logic [31:0] FALLBACK_RESET = 32'h3DCC_CCCD;
    localparam logic [47:0] SEEN_MAX       = 48'hFFFF_FFFF_FFFF;

    localparam int unsigned OUTQ_DEPTH = 8;
    localparam int unsigned OUTQ_AW    = 3;

    typedef struct packed {
        logic        action;
        logic [31:0] energy_bits;
        logic        is_hole;
        logic [31:0] random_fraction;
    } rsmp_in_t;

    typedef struct packed {
        logic [31:0] sample_bits;
        logic        from_store;
        logic        accepted;
        logic [16:0] stored_count;
        logic [47:0] seen_count;
    } rsmp_out_t;

    // Per-word context that travels alongside the index pipeline.
    typedef struct packed {
        logic        act_draw;
        logic        acc;
        logic        append;
        logic [31:0] bits;
        logic [16:0] fill;
        logic [47:0] seen;
    } rsmp_side_t;

    // Finite and not negative (negative zero passes).
    function automatic logic energy_ok(input logic [31:0] b);
        logic not_finite;
        logic negative;
        not_finite = (b[30:23] == 8'hFF);
        negative   = b[31] && (b[30:0] != 31'd0);
        return !not_finite && !negative;
    endfunction

endpackage

// ===== sv/reservoir_sampler.sv =====
// Top level of the reservoir sampler: control state, pipeline and store.
//
// Reservoir sampler (Algorithm R) for float32 energy words. An observe word
// that is not a hole, is finite and not negative (negative zero counts) and
// arrives while the capacity is non-zero raises the saturating seen count;
// it is appended while the store holds fewer than the effective capacity
// (capacity_limit, capped at STORE_DEPTH) and otherwise overwrites entry
// (random_fraction * seen) >> 32 if that index lies below the capacity.
// A draw word returns entry (random_fraction * stored) >> 32, or the
// fallback register when the store is empty. Every word yields one result.
// Throughput is one word per clock while results are taken. Each word passes
// in order the count update at the accepting edge, the split 32x32 / 32x16
// index multiply and its sum, the single-port store access and the write
// into the result queue, where its result word is offered. Up to eight
// words may be in flight; s_ready drops only when eight results are
// outstanding. The store needs no clearing pass, as only entries below
// the fill count are read.
// Write configuration only while no words are in flight; writing
// capacity_limit restarts the reservoir (fill and seen counts cleared).
module reservoir_sampler #(
    parameter int unsigned STORE_DEPTH = 65536
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rsmp_pkg::rsmp_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rsmp_pkg::rsmp_out_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [rsmp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data
);
    import rsmp_pkg::*;

    localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [31:0] DEPTH_W = 32'(STORE_DEPTH);
    localparam logic [16:0] CAP_RESET =
        (DEPTH_W < 32'(CAP_MAX)) ? DEPTH_W[16:0] : CAP_MAX;

    // Configuration and reservoir counts.
    logic [16:0]      cap_reg, cap_next;
    logic [31:0]      fallback_reg;
    logic [16:0]      fill_reg, fill_next;
    logic [47:0]      seen_reg, seen_next;
    logic [OUTQ_AW:0] outst_reg, outst_next;

    logic s_fire, m_fire, cap_wr;
    logic is_obs, acc, append;

    // Stage 1: word with updated counts, ready for the index multiply.
    logic        s1_valid_reg;
    logic [31:0] s1_rnd_reg;
    logic [47:0] s1_n_reg;
    rsmp_side_t  s1_side_reg;
    logic [47:0] n_next;
    rsmp_side_t  side_next;

    // Stage 3: scaled index available, store access issued.
    logic        s3_valid;
    logic [47:0] s3_idx;
    rsmp_side_t  s3_side;
    logic [16:0] s3_last;
    logic        st_wr, st_rd;
    logic [AW-1:0] st_addr;

    // Stage 4: read data back, result assembled.
    logic        s4_valid_reg;
    rsmp_side_t  s4_side_reg;
    logic        s4_from_store_reg;
    logic [31:0] st_rdata;
    rsmp_out_t   q_data;

    assign s_ready = (outst_reg < (OUTQ_AW+1)'(OUTQ_DEPTH));
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign cap_wr  = cfg_wr_en && (cfg_index == CFG_CAPACITY);

    // Filter and count update at acceptance, so the next word sees them.
    always_comb begin
        is_obs    = (s_data.action == ACT_OBSERVE);
        acc       = is_obs && !s_data.is_hole && (cap_reg != '0)
                    && energy_ok(s_data.energy_bits);
        append    = acc && (fill_reg < cap_reg);
        seen_next = seen_reg;
        fill_next = fill_reg;
        if (s_fire && acc && (seen_reg != SEEN_MAX)) begin
            seen_next = seen_reg + 48'd1;
        end
        if (s_fire && append) begin
            fill_next = fill_reg + 17'd1;
        end
        // Observe scales by the new seen count, draw by the fill count.
        n_next = is_obs ? seen_next : 48'(fill_reg);

        side_next.act_draw = !is_obs;
        side_next.acc      = acc;
        side_next.append   = append;
        side_next.bits     = s_data.energy_bits;
        side_next.fill     = fill_next;
        side_next.seen     = seen_next;

        cap_next = cfg_data[16:0];
        if (32'(cfg_data[16:0]) > DEPTH_W) begin
            cap_next = DEPTH_W[16:0];
        end

        outst_next = outst_reg;
        if (s_fire && !m_fire) begin
            outst_next = outst_reg + 1'b1;
        end else if (!s_fire && m_fire) begin
            outst_next = outst_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= CAP_RESET;
            fallback_reg <= FALLBACK_RESET;
            fill_reg     <= '0;
            seen_reg     <= '0;
            outst_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (cap_wr) begin
                // Restart the reservoir on a capacity change.
                cap_reg  <= cap_next;
                fill_reg <= '0;
                seen_reg <= '0;
            end else begin
                fill_reg <= fill_next;
                seen_reg <= seen_next;
            end
            if (cfg_wr_en && (cfg_index == CFG_FALLBACK)) begin
                fallback_reg <= cfg_data;
            end
            outst_reg    <= outst_next;
            s1_valid_reg <= s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        s1_rnd_reg  <= s_data.random_fraction;
        s1_n_reg    <= n_next;
        s1_side_reg <= side_next;
    end

    rsmp_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid_reg),
        .in_rnd    (s1_rnd_reg),
        .in_n      (s1_n_reg),
        .in_side   (s1_side_reg),
        .out_valid (s3_valid),
        .out_idx   (s3_idx),
        .out_side  (s3_side)
    );

    // Store access. Words reach this stage in order and each makes at most
    // one access, so a read always sees every earlier write: no forwarding.
    always_comb begin
        s3_last = s3_side.fill - 17'd1;
        st_wr   = s3_valid && !s3_side.act_draw && s3_side.acc
                  && (s3_side.append || (s3_idx < 48'(cap_reg)));
        st_rd   = s3_valid && s3_side.act_draw && (s3_side.fill != '0);
        if (s3_side.act_draw) begin
            // Clamp a draw index to the last held entry.
            st_addr = (s3_idx >= 48'(s3_side.fill)) ? AW'(s3_last) : AW'(s3_idx);
        end else begin
            // Append lands on the slot just counted in.
            st_addr = s3_side.append ? AW'(s3_last) : AW'(s3_idx);
        end
    end

    rsmp_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .wr_en (st_wr),
        .rd_en (st_rd),
        .addr  (st_addr),
        .wdata (s3_side.bits),
        .rdata (st_rdata)
    );

    always_ff @(posedge aclk) begin
        s4_side_reg       <= s3_side;
        s4_from_store_reg <= st_rd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else begin
            s4_valid_reg <= s3_valid;
        end
    end

    always_comb begin
        q_data.sample_bits = '0;
        if (s4_side_reg.act_draw) begin
            q_data.sample_bits = s4_from_store_reg ? st_rdata : fallback_reg;
        end
        q_data.from_store   = s4_from_store_reg;
        q_data.accepted     = s4_side_reg.acc;
        q_data.stored_count = s4_side_reg.fill;
        q_data.seen_count   = s4_side_reg.seen;
    end

    rsmp_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s4_valid_reg),
        .wr_data  (q_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    a_outst_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        outst_reg <= (OUTQ_AW+1)'(OUTQ_DEPTH))
        else $error("outstanding word count out of range");

    a_fill_in_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= cap_reg)
        else $error("fill count above capacity");

    a_draw_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        st_rd |-> (32'(st_addr) < 32'(s3_side.fill)))
        else $error("draw reads beyond the held entries");

    a_seen_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(cap_wr) |-> seen_reg >= $past(seen_reg))
        else $error("seen count decreased without a restart");

    a_single_access: assert property (@(posedge aclk) disable iff (!aresetn)
        st_wr |-> !st_rd)
        else $error("store read and written by one word");

endmodule

// ===== sv/rsmp_scale.sv =====
// Two-stage scaled index unit: (rnd * n) >> 32 for a 48-bit n.
module rsmp_scale (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  logic [31:0]            in_rnd,
    input  logic [47:0]            in_n,
    input  rsmp_pkg::rsmp_side_t   in_side,
    output logic                   out_valid,
    output logic [47:0]            out_idx,
    output rsmp_pkg::rsmp_side_t   out_side
);
    import rsmp_pkg::*;

    logic        mul_valid_reg;
    logic [63:0] prod_lo_reg;
    logic [47:0] prod_hi_reg;
    rsmp_side_t  mul_side_reg;

    logic        idx_valid_reg;
    logic [47:0] idx_reg;
    logic [47:0] idx_next;
    rsmp_side_t  idx_side_reg;

    // Partial products on the low and high halves of n.
    always_ff @(posedge aclk) begin
        prod_lo_reg  <= 64'(in_rnd) * 64'(in_n[31:0]);
        prod_hi_reg  <= 48'(in_rnd) * 48'(in_n[47:32]);
        mul_side_reg <= in_side;
    end

    assign idx_next = prod_hi_reg + 48'(prod_lo_reg[63:32]);

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        idx_side_reg <= mul_side_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            idx_valid_reg <= 1'b0;
        end else begin
            mul_valid_reg <= in_valid;
            idx_valid_reg <= mul_valid_reg;
        end
    end

    assign out_valid = idx_valid_reg;
    assign out_idx   = idx_reg;
    assign out_side  = idx_side_reg;

endmodule

// ===== sv/rsmp_store.sv =====
// Single-port sample store with registered read data.
module rsmp_store #(
    parameter int unsigned DEPTH = 65536,
    parameter int unsigned AW    = 16
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic          rd_en,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);
    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/rsmp_outq.sv =====
// Result queue that decouples the pipeline from the output handshake.
module rsmp_outq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_valid,
    input  rsmp_pkg::rsmp_out_t   wr_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rsmp_pkg::rsmp_out_t   m_data
);
    import rsmp_pkg::*;

    rsmp_out_t          q_mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] wr_ptr_reg;
    logic [OUTQ_AW-1:0] rd_ptr_reg;
    logic [OUTQ_AW:0]   count_reg;
    logic [OUTQ_AW:0]   count_next;
    logic               pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = q_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (wr_valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!wr_valid && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_valid) begin
            q_mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_valid && !pop |-> count_reg < (OUTQ_AW+1)'(OUTQ_DEPTH))
        else $error("result queue overflow");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("empty queue with unequal pointers");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (OUTQ_AW+1)'(OUTQ_DEPTH))
        else $error("queue count out of range");

endmodule
